// ===== rtl/core/tli_pkg.sv =====
package tli_pkg;

  typedef struct packed {
    logic [7:0] symbol;
    logic       first;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] from_x;
    logic signed [23:0] from_y;
    logic signed [23:0] to_x;
    logic signed [23:0] to_y;
    logic               overflow;
  } out_item_t;

  typedef struct packed {
    logic signed [23:0] start_x;
    logic signed [23:0] start_y;
    logic [23:0]        start_length;
    logic [15:0]        turn_angle;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_DRAW, OP_PLUS, OP_MINUS, OP_SQRT, OP_SQUARE, OP_HALF, OP_PUSH, OP_POP
  } op_t;

  typedef struct packed {
    op_t  op;
    logic first;
  } cmd_t;

  localparam logic [7:0] SYM_F      = 8'h46;
  localparam logic [7:0] SYM_G      = 8'h47;
  localparam logic [7:0] SYM_PLUS   = 8'h2B;
  localparam logic [7:0] SYM_MINUS  = 8'h2D;
  localparam logic [7:0] SYM_SQRT   = 8'h53;
  localparam logic [7:0] SYM_SQUARE = 8'h70;
  localparam logic [7:0] SYM_HALF   = 8'h73;
  localparam logic [7:0] SYM_PUSH   = 8'h5B;
  localparam logic [7:0] SYM_POP    = 8'h5D;

  localparam logic [7:0] CFG_START_X   = 8'd0;
  localparam logic [7:0] CFG_START_Y   = 8'd1;
  localparam logic [7:0] CFG_START_LEN = 8'd2;
  localparam logic [7:0] CFG_TURN      = 8'd3;

  localparam logic signed [23:0] RST_START_X   = 24'sd115200;
  localparam logic signed [23:0] RST_START_Y   = 24'sd115200;
  localparam logic [23:0]        RST_START_LEN = 24'd286720;
  localparam logic [15:0]        RST_TURN      = 16'd10923;
  localparam logic [15:0]        HEADING_UP    = 16'd16384;

  localparam logic [29:0] CORDIC_GAIN   = 30'd652032874;
  localparam logic [31:0] INV_SQRT2_Q32 = 32'd3037000500;
  localparam logic [23:0] LEN_MAX       = 24'hFFFFFF;

  function automatic logic [29:0] atan_lut(input logic [4:0] i);
    logic [29:0] r;
    unique case (i)
      5'd0: r = 30'd536870912;  5'd1: r = 30'd316933406;  5'd2: r = 30'd167458907;
      5'd3: r = 30'd85004756;   5'd4: r = 30'd42667331;   5'd5: r = 30'd21354465;
      5'd6: r = 30'd10679838;   5'd7: r = 30'd5340245;    5'd8: r = 30'd2670163;
      5'd9: r = 30'd1335087;    5'd10: r = 30'd667544;    5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;    5'd13: r = 30'd83443;     5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;     5'd16: r = 30'd10430;     5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;      5'd19: r = 30'd1304;      5'd20: r = 30'd652;
      5'd21: r = 30'd326;       5'd22: r = 30'd163;       5'd23: r = 30'd81;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/tli_ram.sv =====
module tli_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/tli_front.sv =====
module tli_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tli_pkg::in_item_t item,
  output logic              full,
  output logic              q_valid,
  output tli_pkg::cmd_t     q_cmd,
  input  logic              q_take
);
  import tli_pkg::*;

  cmd_t       slot_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       cls;
  logic       acc;

  // classify the symbol before it is queued
  always_comb begin
    cls.first = item.first;
    unique case (item.symbol)
      SYM_F, SYM_G: cls.op = OP_DRAW;
      SYM_PLUS:     cls.op = OP_PLUS;
      SYM_MINUS:    cls.op = OP_MINUS;
      SYM_SQRT:     cls.op = OP_SQRT;
      SYM_SQUARE:   cls.op = OP_SQUARE;
      SYM_HALF:     cls.op = OP_HALF;
      SYM_PUSH:     cls.op = OP_PUSH;
      SYM_POP:      cls.op = OP_POP;
      default:      cls.op = OP_NOP;
    endcase
  end

  assign full    = cnt_r == 2'd2;
  assign acc     = push && !full;
  assign q_valid = cnt_r != 2'd0;
  assign q_cmd   = slot_r[0];

  always_comb begin
    cnt_nxt = cnt_r + 2'(acc) - 2'(q_take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    if (q_take) begin
      slot_r[0] <= slot_r[1];
      if (acc && cnt_r == 2'd1) slot_r[0] <= cls;
      if (acc && cnt_r == 2'd2) slot_r[1] <= cls;
    end else if (acc) begin
      if (cnt_r == 2'd0) slot_r[0] <= cls;
      else slot_r[1] <= cls;
    end
  end
endmodule

// ===== rtl/core/tli_back.sv =====
module tli_back #(
  parameter int STACK_DEPTH  = 32,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tli_pkg::cfg_t      cfg,
  input  logic               q_valid,
  input  tli_pkg::cmd_t      q_cmd,
  output logic               q_take,
  output logic               out_valid,
  output tli_pkg::out_item_t out_item,
  input  logic               out_take
);
  import tli_pkg::*;

  localparam int AW    = STACK_DEPTH > 1 ? $clog2(STACK_DEPTH) : 1;
  localparam int SPW   = $clog2(STACK_DEPTH + 1);
  localparam int NSTEP = CORDIC_STEPS < 24 ? CORDIC_STEPS : 24;
  localparam int SW    = 88;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CORDIC = 6'b000010,
    S_SQRT   = 6'b000100,
    S_MUL    = 6'b001000,
    S_POP    = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic signed [23:0] px_r, py_r;
  logic [15:0]        hd_r;
  logic [23:0]        len_r;
  logic [SPW-1:0]     sp_r;
  logic               stop_r, ovf_r, neg_r, sq_r, ov_r;
  logic signed [42:0] cx_r, cy_r;
  logic signed [33:0] cz_r;
  logic [4:0]         cnt_r;
  logic [55:0]        prod_r;
  logic [36:0]        sv_r, sres_r;
  logic [35:0]        sbit_r;
  out_item_t          oi_r;

  logic signed [23:0] ex, ey;
  logic [15:0]        ehd;
  logic [23:0]        elen;
  logic [SPW-1:0]     esp;
  logic               estop, eovf;
  logic [15:0]        hd_new;
  logic [SPW-1:0]     sp_new;
  logic               ovf_new, stop_new;
  logic signed [33:0] z0;
  logic               wr_en, rd_en;
  logic [AW-1:0]      waddr, raddr;
  logic [SW-1:0]      rdata;
  logic signed [42:0] fx, fy, sx, sy;
  logic signed [43:0] rx, ry;
  logic [36:0]        st;
  logic [56:0]        half_sum;
  logic               emit_go;

  assign ex    = q_cmd.first ? cfg.start_x : px_r;
  assign ey    = q_cmd.first ? cfg.start_y : py_r;
  assign ehd   = q_cmd.first ? HEADING_UP : hd_r;
  assign elen  = q_cmd.first ? cfg.start_length : len_r;
  assign esp   = q_cmd.first ? '0 : sp_r;
  assign estop = q_cmd.first ? 1'b0 : stop_r;
  assign eovf  = q_cmd.first ? 1'b0 : ovf_r;

  assign q_take  = state_r == S_IDLE && q_valid;
  assign wr_en   = q_take && !estop && q_cmd.op == OP_PUSH && esp < SPW'(STACK_DEPTH);
  assign rd_en   = q_take && !estop && q_cmd.op == OP_POP && esp != '0;
  assign waddr   = esp[AW-1:0];
  assign raddr   = AW'(esp - SPW'(1));

  // turtle state update for the turn, push and pop commands
  always_comb begin
    hd_new   = ehd;
    sp_new   = esp;
    ovf_new  = eovf;
    stop_new = estop;
    if (!estop) begin
      unique case (q_cmd.op)
        OP_PLUS:  hd_new = ehd + cfg.turn_angle;
        OP_MINUS: hd_new = ehd - cfg.turn_angle;
        OP_PUSH: begin
          if (esp < SPW'(STACK_DEPTH)) sp_new = esp + SPW'(1);
          else ovf_new = 1'b1;
        end
        OP_POP: begin
          if (esp != '0) sp_new = esp - SPW'(1);
          else stop_new = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // fold heading into the right half plane, negate the result later
  always_comb begin
    z0 = 34'(signed'({ehd, 16'h0000}));
    if (z0 > 34'sd1073741824) z0 = z0 - 34'sd2147483648;
    else if (z0 < -34'sd1073741824) z0 = z0 + 34'sd2147483648;
  end

  tli_ram #(.WIDTH(SW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(wr_en), .waddr(waddr), .wdata({ex, ey, ehd, elen}),
    .re(rd_en), .raddr(raddr), .rdata(rdata)
  );

  assign sx = cx_r >>> cnt_r;
  assign sy = cy_r >>> cnt_r;
  assign fx = neg_r ? -cx_r : cx_r;
  assign fy = neg_r ? -cy_r : cy_r;
  assign rx = (44'(fx) + 44'sd524288) >>> 20;
  assign ry = (44'(fy) + 44'sd524288) >>> 20;
  assign st = sres_r + 37'(sbit_r);
  assign half_sum = 57'(prod_r) + 57'h80000000;
  assign emit_go  = !out_valid || out_take;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_take && !estop) begin
          unique case (q_cmd.op)
            OP_DRAW:             state_nxt = S_CORDIC;
            OP_SQRT:             state_nxt = S_SQRT;
            OP_SQUARE, OP_HALF:  state_nxt = S_MUL;
            OP_POP:              state_nxt = esp != '0 ? S_POP : S_IDLE;
            default:             state_nxt = S_IDLE;
          endcase
        end
      end
      S_CORDIC: if (cnt_r == 5'(NSTEP - 1)) state_nxt = S_EMIT;
      S_SQRT:   if (cnt_r == 5'd17) state_nxt = S_IDLE;
      S_MUL:    state_nxt = S_IDLE;
      S_POP:    state_nxt = S_IDLE;
      S_EMIT:   if (emit_go) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (state_r == S_EMIT && emit_go) begin
      ov_r <= 1'b1;
    end else if (out_take) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      px_r    <= RST_START_X;
      py_r    <= RST_START_Y;
      hd_r    <= HEADING_UP;
      len_r   <= RST_START_LEN;
      sp_r    <= '0;
      stop_r  <= 1'b0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (q_take) begin
            px_r <= ex; py_r <= ey; hd_r <= hd_new; len_r <= elen;
            sp_r <= sp_new; stop_r <= stop_new; ovf_r <= ovf_new;
            if (!estop) begin
              unique case (q_cmd.op)
                OP_DRAW: begin
                  cx_r  <= 43'(({32'h0, elen} * {26'h0, CORDIC_GAIN}) >> 14);
                  cy_r  <= '0;
                  cz_r  <= z0;
                  neg_r <= z0 != 34'(signed'({ehd, 16'h0000}));
                  cnt_r <= '0;
                end
                OP_SQRT: begin
                  sv_r   <= {1'b0, elen, 12'h000};
                  sres_r <= '0;
                  sbit_r <= 36'h400000000;
                  cnt_r  <= '0;
                end
                OP_SQUARE: begin
                  prod_r <= 56'(elen) * 56'(elen);
                  sq_r   <= 1'b1;
                end
                OP_HALF: begin
                  prod_r <= 56'(elen) * 56'(INV_SQRT2_Q32);
                  sq_r   <= 1'b0;
                end
                default: ;
              endcase
            end
          end
        end
        S_CORDIC: begin
          if (cz_r >= 0) begin
            cx_r <= cx_r - sy;
            cy_r <= cy_r + sx;
            cz_r <= cz_r - 34'(atan_lut(cnt_r));
          end else begin
            cx_r <= cx_r + sy;
            cy_r <= cy_r - sx;
            cz_r <= cz_r + 34'(atan_lut(cnt_r));
          end
          cnt_r <= cnt_r + 5'd1;
        end
        S_SQRT: begin
          if (sv_r >= st) begin
            sv_r   <= sv_r - st;
            sres_r <= (sres_r >> 1) + 37'(sbit_r);
          end else begin
            sres_r <= sres_r >> 1;
          end
          sbit_r <= sbit_r >> 2;
          cnt_r  <= cnt_r + 5'd1;
          if (cnt_r == 5'd17) begin
            if (sv_r >= st) len_r <= 24'((sres_r >> 1) + 37'(sbit_r));
            else len_r <= 24'(sres_r >> 1);
          end
        end
        S_MUL: begin
          if (sq_r) len_r <= prod_r[47:36] != '0 ? LEN_MAX : prod_r[35:12];
          else len_r <= half_sum[55:32];
        end
        S_POP: {px_r, py_r, hd_r, len_r} <= rdata;
        S_EMIT: begin
          if (emit_go) begin
            oi_r.from_x    <= px_r;
            oi_r.from_y    <= py_r;
            oi_r.to_x      <= px_r - rx[23:0];
            oi_r.to_y      <= py_r - ry[23:0];
            oi_r.overflow  <= ovf_r;
            px_r           <= px_r - rx[23:0];
            py_r           <= py_r - ry[23:0];
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = ov_r;
  assign out_item  = oi_r;
endmodule

// ===== rtl/core/turtle_line_interpreter.sv =====
// turtle line interpreter
// input: queue style, one symbol and a first marker per transaction, taken
// when in_push is high and in_full is low; a two-entry command queue sits
// in front of the execution unit.
// results: one segment per drawn F or G, held on out_item while out_empty
// is low and taken with out_pop; other symbols give no result.
// config: cfg_valid/cfg_ready (always ready) write start_x (0), start_y (1),
// start_length (2) and turn_angle (3); the start values act at the next
// first marker.
// execution: a draw runs the iterative cordic rotator, then the emit state;
// S runs the bit-pair square root; p and s use a registered multiplier
// product; ] waits for the stack memory read; other symbols are done in
// the idle state in which they are taken.
// the result register frees the rotator, but a draw waits in place while a
// previous result is still not popped, and the command queue then fills.
// reset clears the queues and loads the turtle from the reset register values;
// the bracket stack needs no clearing pass.
module turtle_line_interpreter #(
  parameter int STACK_DEPTH  = 32,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  tli_pkg::in_item_t  in_item,
  output logic               in_full,
  output logic               out_empty,
  output tli_pkg::out_item_t out_item,
  input  logic               out_pop,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [23:0]        cfg_data
);
  import tli_pkg::*;

  cfg_t cfg_r;
  logic q_valid, q_take, ov;
  cmd_t q_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_x      <= RST_START_X;
      cfg_r.start_y      <= RST_START_Y;
      cfg_r.start_length <= RST_START_LEN;
      cfg_r.turn_angle   <= RST_TURN;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_START_X:   cfg_r.start_x      <= cfg_data;
        CFG_START_Y:   cfg_r.start_y      <= cfg_data;
        CFG_START_LEN: cfg_r.start_length <= cfg_data;
        CFG_TURN:      cfg_r.turn_angle   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  tli_front u_front (
    .clk(clk), .rst_n(rst_n), .push(in_push), .item(in_item), .full(in_full),
    .q_valid(q_valid), .q_cmd(q_cmd), .q_take(q_take)
  );

  tli_back #(.STACK_DEPTH(STACK_DEPTH), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .q_valid(q_valid), .q_cmd(q_cmd),
    .q_take(q_take), .out_valid(ov), .out_item(out_item),
    .out_take(out_pop && ov)
  );

  assign out_empty = !ov;
endmodule

// ===== rtl/core/tli_checker.sv =====
module tli_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_full,
  input logic               out_empty,
  input logic               out_pop,
  input tli_pkg::out_item_t out_item,
  input logic               cfg_ready
);
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");
  a_rst_full: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input queue full after reset");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty)
    else $error("result dropped without pop");
  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> $stable(out_item))
    else $error("result changed while waiting");
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config port stalled");
endmodule

bind turtle_line_interpreter tli_checker u_tli_checker (
  .clk(clk), .rst_n(rst_n), .in_full(in_full), .out_empty(out_empty),
  .out_pop(out_pop), .out_item(out_item), .cfg_ready(cfg_ready)
);
